/* src/quaternion_vector_rotate_top_defines.svh */
`ifndef QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATE_TOP_DEFINES_SVH

// Same-cycle implication on clk, off while rst_n is low
`define QVR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk, off while rst_n is low
`define QVR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/qvr_pkg.sv */
`default_nettype none

package qvr_pkg;

  localparam int QUAT_W = 16;

  function automatic int ham_out_w(input int aw, input int bw, input int frac);
    int sw;
    int ew;
    sw = aw + bw + 2;
    ew = (sw > frac + 1) ? sw : frac + 2;
    return ew - frac;
  endfunction

endpackage

`default_nettype wire

/* src/quaternion_vector_rotate_top.sv */
`default_nettype none
`include "quaternion_vector_rotate_top_defines.svh"

// Quaternion vector rotation: out = vector part of q * (0,v) * conj(q).
// Request channel: drive in_quat_* (signed Q2.QUAT_FRAC) and in_vec_* with
// start high; the request is taken at the rising edge where start is high and
// busy is low. busy is high while rst_n is low and in the first cycle after
// reset, and low otherwise; a request can be taken in every cycle where busy is low.
// Result channel: out_valid is high for exactly one cycle with out_rot_* and
// out_clamped; out_clamped marks that at least one component hit a rail.
// Throughput: one request per cycle, results in request order.
// Pipeline: two stages for q*(0,v) (multipliers, then sum and round), two for
// the product with conj(q), one for saturation; the multiplier stages set the
// clock period.
// Reset (rst_n low, synchronous) empties the pipeline; requests in flight are
// dropped. The receiver cannot stall, so results leave as they are done.
module quaternion_vector_rotate_top #(
  parameter int VEC_WIDTH = 16,
  parameter int QUAT_FRAC = 14
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic signed [qvr_pkg::QUAT_W-1:0]     in_quat_w,
  input  wire logic signed [qvr_pkg::QUAT_W-1:0]     in_quat_x,
  input  wire logic signed [qvr_pkg::QUAT_W-1:0]     in_quat_y,
  input  wire logic signed [qvr_pkg::QUAT_W-1:0]     in_quat_z,
  input  wire logic signed [VEC_WIDTH-1:0]           in_vec_x,
  input  wire logic signed [VEC_WIDTH-1:0]           in_vec_y,
  input  wire logic signed [VEC_WIDTH-1:0]           in_vec_z,
  output logic                                       out_valid,
  output logic signed [VEC_WIDTH-1:0]                out_rot_x,
  output logic signed [VEC_WIDTH-1:0]                out_rot_y,
  output logic signed [VEC_WIDTH-1:0]                out_rot_z,
  output logic                                       out_clamped
);

  localparam int QW  = qvr_pkg::QUAT_W;
  localparam int CW  = QW + 1;
  localparam int RW1 = qvr_pkg::ham_out_w(QW, VEC_WIDTH, QUAT_FRAC);
  localparam int RW2 = qvr_pkg::ham_out_w(RW1, CW, QUAT_FRAC);

  logic                        busy_r;
  logic                        accept;
  logic signed [QW-1:0]        q_a [4];
  logic signed [VEC_WIDTH-1:0] p_b [4];
  logic signed [CW-1:0]        qc_d1_r [4];
  logic signed [CW-1:0]        qc_d2_r [4];
  logic                        t1_valid;
  logic signed [RW1-1:0]       t1 [4];
  logic                        t2_valid;
  logic signed [RW2-1:0]       t2 [4];
  logic signed [RW2-1:0]       t2_vec [3];
  logic signed [VEC_WIDTH-1:0] rot [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  assign q_a = '{in_quat_w, in_quat_x, in_quat_y, in_quat_z};
  assign p_b = '{'0, in_vec_x, in_vec_y, in_vec_z};

  // hold conj(q) alongside the first product
  always_ff @(posedge clk) begin
    qc_d1_r[0] <= CW'(in_quat_w);
    qc_d1_r[1] <= -CW'(in_quat_x);
    qc_d1_r[2] <= -CW'(in_quat_y);
    qc_d1_r[3] <= -CW'(in_quat_z);
    qc_d2_r    <= qc_d1_r;
  end

  qvr_ham #(
    .AW   (QW),
    .BW   (VEC_WIDTH),
    .FRAC (QUAT_FRAC)
  ) u_ham_qp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_a      (q_a),
    .in_b      (p_b),
    .out_valid (t1_valid),
    .out_r     (t1)
  );

  qvr_ham #(
    .AW   (RW1),
    .BW   (CW),
    .FRAC (QUAT_FRAC)
  ) u_ham_tq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (t1_valid),
    .in_a      (t1),
    .in_b      (qc_d2_r),
    .out_valid (t2_valid),
    .out_r     (t2)
  );

  assign t2_vec = '{t2[1], t2[2], t2[3]};

  qvr_sat #(
    .IW (RW2),
    .VW (VEC_WIDTH)
  ) u_sat (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (t2_valid),
    .in_v        (t2_vec),
    .out_valid   (out_valid),
    .out_rot     (rot),
    .out_clamped (out_clamped)
  );

  assign out_rot_x = rot[0];
  assign out_rot_y = rot[1];
  assign out_rot_z = rot[2];

  `QVR_ASSERT_IMP(a_out_from_request, out_valid, $past(accept, 5), "result without request")
  `QVR_ASSERT_IMP(a_busy_after_reset, $past(!rst_n), busy, "request taken straight after reset")
  `QVR_ASSERT_NXT(a_busy_one_cycle, busy, !busy, "busy held beyond reset recovery")

endmodule

`default_nettype wire

/* src/qvr_ham.sv */
`default_nettype none
`include "quaternion_vector_rotate_top_defines.svh"

module qvr_ham #(
  parameter int AW   = qvr_pkg::QUAT_W,
  parameter int BW   = qvr_pkg::QUAT_W,
  parameter int FRAC = 14,
  localparam int RW  = qvr_pkg::ham_out_w(AW, BW, FRAC)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic signed [AW-1:0] in_a [4],
  input  wire logic signed [BW-1:0] in_b [4],
  output logic                      out_valid,
  output logic signed [RW-1:0]      out_r [4]
);

  localparam int PW = AW + BW;
  localparam int SW = PW + 2;
  localparam int EW = (SW > FRAC + 1) ? SW : FRAC + 2;
  localparam logic signed [EW-1:0] HALF = EW'(1) << (FRAC - 1);

  logic                 valid1_r;
  logic                 valid2_r;
  logic signed [PW-1:0] prod_r [4][4];
  logic signed [EW-1:0] ext [4][4];
  logic signed [EW-1:0] sum [4];
  logic signed [EW-1:0] rnd [4];
  logic signed [RW-1:0] res_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else begin
      valid1_r <= in_valid;
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_r[i][j] <= in_a[i] * in_b[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        ext[i][j] = EW'(prod_r[i][j]);
      end
    end
    sum[0] = ext[0][0] - ext[1][1] - ext[2][2] - ext[3][3];
    sum[1] = ext[0][1] + ext[1][0] + ext[2][3] - ext[3][2];
    sum[2] = ext[0][2] - ext[1][3] + ext[2][0] + ext[3][1];
    sum[3] = ext[0][3] + ext[1][2] - ext[2][1] + ext[3][0];
    for (int k = 0; k < 4; k++) begin
      rnd[k] = sum[k] + HALF;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      res_r[k] <= rnd[k][EW-1:FRAC];
    end
  end

  assign out_valid = valid2_r;
  assign out_r     = res_r;

  `QVR_ASSERT_IMP(a_ham_latency, out_valid, $past(in_valid, 2), "product without request")

endmodule

`default_nettype wire

/* src/qvr_sat.sv */
`default_nettype none
`include "quaternion_vector_rotate_top_defines.svh"

module qvr_sat #(
  parameter int IW = 32,
  parameter int VW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic signed [IW-1:0] in_v [3],
  output logic                      out_valid,
  output logic signed [VW-1:0]      out_rot [3],
  output logic                      out_clamped
);

  localparam logic [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic [VW-1:0] VMIN = ~VMAX;

  logic                 valid_r;
  logic                 clamped_r;
  logic signed [VW-1:0] rot_r [3];
  logic signed [VW-1:0] sat_val [3];
  logic [2:0]           ovf;

  if (IW > VW) begin : g_clamp
    logic [IW-VW:0] hi [3];
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        hi[k]  = in_v[k][IW-1:VW-1];
        ovf[k] = ~((&hi[k]) | ~(|hi[k]));
        if (ovf[k]) begin
          sat_val[k] = in_v[k][IW-1] ? VMIN : VMAX;
        end else begin
          sat_val[k] = in_v[k][VW-1:0];
        end
      end
    end
  end else begin : g_extend
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        ovf[k]     = 1'b0;
        sat_val[k] = VW'(in_v[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rot_r     <= sat_val;
    clamped_r <= |ovf;
  end

  assign out_valid   = valid_r;
  assign out_rot     = rot_r;
  assign out_clamped = clamped_r;

  `QVR_ASSERT_IMP(a_clamp_at_rail, out_valid && out_clamped,
                  out_rot[0] == VMAX || out_rot[0] == VMIN ||
                  out_rot[1] == VMAX || out_rot[1] == VMIN ||
                  out_rot[2] == VMAX || out_rot[2] == VMIN,
                  "clamp flag without a component at a rail")

endmodule

`default_nettype wire

/* tb/quaternion_vector_rotate_checker.sv */
`timescale 1ns / 1ps

module quaternion_vector_rotate_checker #(
  parameter int VEC_WIDTH = 16,
  parameter int QUAT_FRAC = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic signed [qvr_pkg::QUAT_W-1:0]   in_quat_w,
  input  logic signed [qvr_pkg::QUAT_W-1:0]   in_quat_x,
  input  logic signed [qvr_pkg::QUAT_W-1:0]   in_quat_y,
  input  logic signed [qvr_pkg::QUAT_W-1:0]   in_quat_z,
  input  logic signed [VEC_WIDTH-1:0]         in_vec_x,
  input  logic signed [VEC_WIDTH-1:0]         in_vec_y,
  input  logic signed [VEC_WIDTH-1:0]         in_vec_z,
  input  logic                                out_valid,
  input  logic signed [VEC_WIDTH-1:0]         out_rot_x,
  input  logic signed [VEC_WIDTH-1:0]         out_rot_y,
  input  logic signed [VEC_WIDTH-1:0]         out_rot_z,
  input  logic                                out_clamped,
  output int                                  mismatches,
  output int                                  pending,
  output int                                  rotations_checked,
  output int                                  rotations_clamped
);

  typedef struct {
    longint w;
    longint x;
    longint y;
    longint z;
  } quat_t;

  typedef struct {
    logic signed [VEC_WIDTH-1:0] x;
    logic signed [VEC_WIDTH-1:0] y;
    logic signed [VEC_WIDTH-1:0] z;
    logic                        clamped;
  } rotation_t;

  rotation_t rotations_due[$];

  initial begin
    mismatches        = 0;
    pending           = 0;
    rotations_checked = 0;
    rotations_clamped = 0;
  end

  // round to nearest, ties upward: add half an LSB, then floor shift
  function automatic longint round_frac(input longint v);
    return (v + (longint'(1) << (QUAT_FRAC - 1))) >>> QUAT_FRAC;
  endfunction

  function automatic quat_t hamilton_product(input quat_t a, input quat_t b);
    quat_t r;
    r.w = round_frac(a.w * b.w - a.x * b.x - a.y * b.y - a.z * b.z);
    r.x = round_frac(a.w * b.x + a.x * b.w + a.y * b.z - a.z * b.y);
    r.y = round_frac(a.w * b.y - a.x * b.z + a.y * b.w + a.z * b.x);
    r.z = round_frac(a.w * b.z + a.x * b.y - a.y * b.x + a.z * b.w);
    return r;
  endfunction

  function automatic logic signed [VEC_WIDTH-1:0] saturate(input longint v, inout logic hit);
    longint hi;
    longint lo;
    hi = (longint'(1) << (VEC_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      v   = hi;
      hit = 1'b1;
    end else if (v < lo) begin
      v   = lo;
      hit = 1'b1;
    end
    return v[VEC_WIDTH-1:0];
  endfunction

  function automatic rotation_t rotate_vector();
    quat_t     q;
    quat_t     qc;
    quat_t     p;
    quat_t     t;
    rotation_t r;
    q.w  = in_quat_w;
    q.x  = in_quat_x;
    q.y  = in_quat_y;
    q.z  = in_quat_z;
    qc.w = q.w;
    qc.x = -q.x;
    qc.y = -q.y;
    qc.z = -q.z;
    p.w  = 0;
    p.x  = in_vec_x;
    p.y  = in_vec_y;
    p.z  = in_vec_z;
    t = hamilton_product(hamilton_product(q, p), qc);
    r.clamped = 1'b0;
    r.x = saturate(t.x, r.clamped);
    r.y = saturate(t.y, r.clamped);
    r.z = saturate(t.z, r.clamped);
    return r;
  endfunction

  always @(posedge clk) begin
    rotation_t want;
    if (rst_n) begin
      if (start && !busy) begin
        rotations_due.push_back(rotate_vector());
      end
      if (out_valid) begin
        if (rotations_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result x=%0d y=%0d z=%0d clamped=%0b", $time,
                     out_rot_x, out_rot_y, out_rot_z, out_clamped);
          end
        end else begin
          want = rotations_due.pop_front();
          rotations_checked++;
          if (want.clamped) rotations_clamped++;
          if (out_rot_x !== want.x || out_rot_y !== want.y || out_rot_z !== want.z ||
              out_clamped !== want.clamped) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch expected x=%0d y=%0d z=%0d clamped=%0b", $time,
                       want.x, want.y, want.z, want.clamped);
              $display("%0t:          actual   x=%0d y=%0d z=%0d clamped=%0b", $time,
                       out_rot_x, out_rot_y, out_rot_z, out_clamped);
            end
          end
        end
      end
    end
    pending = rotations_due.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  localparam int VEC_WIDTH = 16;
  localparam int QUAT_FRAC = 14;
  localparam int RANDOM_PER_PHASE = 545;

  logic                              clk;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic signed [qvr_pkg::QUAT_W-1:0] in_quat_w;
  logic signed [qvr_pkg::QUAT_W-1:0] in_quat_x;
  logic signed [qvr_pkg::QUAT_W-1:0] in_quat_y;
  logic signed [qvr_pkg::QUAT_W-1:0] in_quat_z;
  logic signed [VEC_WIDTH-1:0]       in_vec_x;
  logic signed [VEC_WIDTH-1:0]       in_vec_y;
  logic signed [VEC_WIDTH-1:0]       in_vec_z;
  logic                              out_valid;
  logic signed [VEC_WIDTH-1:0]       out_rot_x;
  logic signed [VEC_WIDTH-1:0]       out_rot_y;
  logic signed [VEC_WIDTH-1:0]       out_rot_z;
  logic                              out_clamped;

  int mismatches;
  int pending;
  int rotations_checked;
  int rotations_clamped;
  int idle_pct;
  int idle_pct_by_phase[3] = '{0, 54, 16};

  quaternion_vector_rotate_top #(
    .VEC_WIDTH(VEC_WIDTH),
    .QUAT_FRAC(QUAT_FRAC)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_quat_w  (in_quat_w),
    .in_quat_x  (in_quat_x),
    .in_quat_y  (in_quat_y),
    .in_quat_z  (in_quat_z),
    .in_vec_x   (in_vec_x),
    .in_vec_y   (in_vec_y),
    .in_vec_z   (in_vec_z),
    .out_valid  (out_valid),
    .out_rot_x  (out_rot_x),
    .out_rot_y  (out_rot_y),
    .out_rot_z  (out_rot_z),
    .out_clamped(out_clamped)
  );

  quaternion_vector_rotate_checker #(
    .VEC_WIDTH(VEC_WIDTH),
    .QUAT_FRAC(QUAT_FRAC)
  ) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_quat_w        (in_quat_w),
    .in_quat_x        (in_quat_x),
    .in_quat_y        (in_quat_y),
    .in_quat_z        (in_quat_z),
    .in_vec_x         (in_vec_x),
    .in_vec_y         (in_vec_y),
    .in_vec_z         (in_vec_z),
    .out_valid        (out_valid),
    .out_rot_x        (out_rot_x),
    .out_rot_y        (out_rot_y),
    .out_rot_z        (out_rot_z),
    .out_clamped      (out_clamped),
    .mismatches       (mismatches),
    .pending          (pending),
    .rotations_checked(rotations_checked),
    .rotations_clamped(rotations_clamped)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int span(input int lim);
    return int'($urandom_range(2 * lim)) - lim;
  endfunction

  // hold the request until taken, then idle for a while at random
  task automatic issue_rotation(input int qw, input int qx, input int qy, input int qz,
                                input int vx, input int vy, input int vz);
    in_quat_w <= 16'(qw);
    in_quat_x <= 16'(qx);
    in_quat_y <= 16'(qy);
    in_quat_z <= 16'(qz);
    in_vec_x  <= VEC_WIDTH'(vx);
    in_vec_y  <= VEC_WIDTH'(vy);
    in_vec_z  <= VEC_WIDTH'(vz);
    start     <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic random_rotation();
    case ($urandom_range(3))
      0: issue_rotation($urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom);
      1: issue_rotation(span(8192), span(8192), span(8192), span(8192),
                        $urandom, $urandom, $urandom);
      2: begin
        case ($urandom_range(3))
          0: issue_rotation(span(16384), span(2048), span(2048), span(2048),
                            span(20000), span(20000), span(20000));
          1: issue_rotation(span(2048), span(16384), span(2048), span(2048),
                            span(20000), span(20000), span(20000));
          2: issue_rotation(span(2048), span(2048), span(16384), span(2048),
                            span(20000), span(20000), span(20000));
          default: issue_rotation(span(2048), span(2048), span(2048), span(16384),
                                  span(20000), span(20000), span(20000));
        endcase
      end
      default: issue_rotation($urandom, $urandom, $urandom, $urandom,
                              span(255), span(255), span(255));
    endcase
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_quat_w = '0;
    in_quat_x = '0;
    in_quat_y = '0;
    in_quat_z = '0;
    in_vec_x  = '0;
    in_vec_y  = '0;
    in_vec_z  = '0;
    idle_pct  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    issue_rotation(0, 0, 0, 0, 0, 0, 0);
    issue_rotation(16384, 0, 0, 0, 32767, -32768, 1);
    issue_rotation(16384, 0, 0, 0, -1, 0, -32768);
    issue_rotation(11585, 0, 0, 11585, 10000, 0, 0);
    issue_rotation(11585, 11585, 0, 0, 0, 10000, -5000);
    issue_rotation(11585, 0, 11585, 0, 3000, -3000, 20000);
    issue_rotation(0, 16384, 0, 0, 1234, -32768, 32767);
    issue_rotation(-16384, 0, 0, 0, 1, 2, 3);
    issue_rotation(-32768, -32768, -32768, -32768, 32767, 32767, 32767);
    issue_rotation(32767, 32767, 32767, 32767, -32768, -32768, -32768);
    issue_rotation(-32768, 0, 0, 0, 32767, 32767, 32767);
    issue_rotation(32767, -32768, 32767, -32768, -32768, -32768, -32768);
    issue_rotation(4096, 0, 0, 0, 32767, -32768, 100);
    issue_rotation(1, 1, 1, 1, 32767, 32767, 32767);
    issue_rotation(-1, -1, -1, -1, -32768, 32767, -32768);
    issue_rotation(0, 0, 0, -32768, -32768, 1, -1);
    issue_rotation(8192, 8192, 8192, 8192, -12345, 23456, -7);
    issue_rotation(16384, 0, 0, 0, 0, 0, 0);
    issue_rotation(23170, 0, 0, 23170, 30000, 30000, 0);
    issue_rotation(8192, -8192, 8192, -8192, 8191, -8192, 1);

    foreach (idle_pct_by_phase[ph]) begin
      idle_pct = idle_pct_by_phase[ph];
      repeat (RANDOM_PER_PHASE) random_rotation();
    end
    start <= 1'b0;

    wait (pending == 0);
    repeat (10) @(posedge clk);
    $display("Rotations checked: %0d, %0d of them saturated on at least one axis.",
             rotations_checked, rotations_clamped);
    $display("Requests sent back to back, then with the sender idle 54%% and 16%% of cycles.");
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
